// ===== design/bbt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// block buffer tag table. Depends on nothing; every other design file uses it.

package bbt_pkg;

    // Table geometry.
    localparam int SLOTS     = 32;
    localparam int DISK_SIZE = 8192;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TAG_W  = (DISK_SIZE > 1) ? $clog2(DISK_SIZE) : 1;

    // Victim search examines GROUP ages per cycle.
    localparam int GROUP    = 8;
    localparam int GSEL_W   = $clog2(GROUP);
    localparam int NGROUPS  = (SLOTS + GROUP - 1) / GROUP;
    localparam int GRP_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int GRP_LAST = NGROUPS - 1;
    localparam int IDX_W    = GRP_W + GSEL_W;

    // Field widths of the request and result.
    localparam int FUNC_W     = 2;
    localparam int BLK_W      = 14;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 5;
    localparam int WB_BLK_W   = 13;
    localparam int AGE_W      = 16;

    // Operation codes; any other code behaves as a lookup.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOB  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // Ages: minus one after reset, zero once a slot is allocated.
    localparam logic signed [AGE_W-1:0] AGE_RESET = '1;
    localparam logic signed [AGE_W-1:0] AGE_NEW   = '0;

    typedef struct packed {
        logic load;          // capture the accepted request
        logic eval_commit;   // apply a lookup, mark or free-slot allocation
        logic scan_init;     // start the victim search
        logic scan_step;     // examine one group of ages
        logic evict_commit;  // replace the chosen victim
        logic out_load;      // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic oob;           // block number at or beyond the disk size
        logic is_alloc;      // request is an allocation
        logic free_found;    // at least one slot is free
        logic scan_last;     // victim search is at its last group
    } t_dp_sts;

endpackage

// ===== design/bbt_dp.sv =====
// Datapath of the block buffer tag table: slot flags, tags and ages, tag
// compare, free-slot and victim search, result and output registers. Uses bbt_pkg.

module bbt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bbt_pkg::t_dp_cmd                    i_cmd,
    output bbt_pkg::t_dp_sts                    o_sts,
    input  logic [bbt_pkg::FUNC_W-1:0]          i_func,
    input  logic [bbt_pkg::BLK_W-1:0]           i_block_num,
    output logic [bbt_pkg::STATUS_W-1:0]        o_status,
    output logic [bbt_pkg::SLOT_OUT_W-1:0]      o_slot,
    output logic                                o_writeback,
    output logic [bbt_pkg::WB_BLK_W-1:0]        o_writeback_block
);

    localparam int SLOTS      = bbt_pkg::SLOTS;
    localparam int SLOT_W     = bbt_pkg::SLOT_W;
    localparam int TAG_W      = bbt_pkg::TAG_W;
    localparam int AGE_W      = bbt_pkg::AGE_W;
    localparam int GRP_W      = bbt_pkg::GRP_W;
    localparam int GSEL_W     = bbt_pkg::GSEL_W;
    localparam int IDX_W      = bbt_pkg::IDX_W;
    localparam int CMP_W      = bbt_pkg::BLK_W + 1;
    localparam int SLOT_OUT_W = bbt_pkg::SLOT_OUT_W;
    localparam int WB_BLK_W   = bbt_pkg::WB_BLK_W;

    logic [bbt_pkg::FUNC_W-1:0]   r_func;
    logic [bbt_pkg::BLK_W-1:0]    r_blk;

    logic [SLOTS-1:0]             r_slot_valid;
    logic [SLOTS-1:0]             r_slot_dirty;
    logic [TAG_W-1:0]             r_slot_tag [SLOTS];
    logic signed [AGE_W-1:0]      r_slot_age [SLOTS];

    logic signed [AGE_W-1:0]      r_best;
    logic [SLOT_W-1:0]            r_victim;
    logic [GRP_W-1:0]             r_grp;
    logic signed [AGE_W-1:0]      n_best;
    logic [SLOT_W-1:0]            n_victim;

    logic [bbt_pkg::STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]            r_res_slot;
    logic                         r_res_wb;
    logic [TAG_W-1:0]             r_res_wbblk;

    logic [bbt_pkg::STATUS_W-1:0] r_o_status;
    logic [SLOT_OUT_W-1:0]        r_o_slot;
    logic                         r_o_wb;
    logic [WB_BLK_W-1:0]          r_o_wbblk;

    logic                         w_oob;
    logic                         w_alloc;
    logic                         w_mark;
    logic [TAG_W-1:0]             w_tag;
    logic                         w_hit;
    logic [SLOT_W-1:0]            w_hit_idx;
    logic                         w_free;
    logic [SLOT_W-1:0]            w_free_idx;

    assign w_oob   = ({1'b0, r_blk} >= CMP_W'(bbt_pkg::DISK_SIZE));
    assign w_alloc = (r_func == bbt_pkg::FUNC_ALLOC);
    assign w_mark  = (r_func == bbt_pkg::FUNC_MARK);
    assign w_tag   = TAG_W'(r_blk);

    // Parallel tag compare and free-slot search, lowest index first.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_slot_valid[i] && (r_slot_tag[i] == w_tag)) begin
                w_hit     = 1'b1;
                w_hit_idx = SLOT_W'(i);
            end
            if (!r_slot_valid[i]) begin
                w_free     = 1'b1;
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    // One group of ages against the running maximum; a strictly greater age
    // is needed to move the victim, so the lowest index wins a tie.
    always_comb begin
        logic [IDX_W-1:0] v_idx;
        n_best   = r_best;
        n_victim = r_victim;
        for (int k = 0; k < bbt_pkg::GROUP; k++) begin
            v_idx = {r_grp, GSEL_W'(k)};
            if ((int'(v_idx) < SLOTS) && (r_slot_age[v_idx[SLOT_W-1:0]] > n_best)) begin
                n_best   = r_slot_age[v_idx[SLOT_W-1:0]];
                n_victim = v_idx[SLOT_W-1:0];
            end
        end
    end

    always_comb begin
        o_sts.oob        = w_oob;
        o_sts.is_alloc   = w_alloc;
        o_sts.free_found = w_free;
        o_sts.scan_last  = (r_grp == GRP_W'(bbt_pkg::GRP_LAST));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_blk  <= i_block_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_slot_dirty <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_age[i] <= bbt_pkg::AGE_RESET;
            end
        end else if (i_cmd.eval_commit && !w_oob) begin
            if (w_alloc) begin
                r_slot_valid[w_free_idx] <= 1'b1;
                r_slot_dirty[w_free_idx] <= 1'b0;
                r_slot_age[w_free_idx]   <= bbt_pkg::AGE_NEW;
            end else if (w_mark && w_hit) begin
                r_slot_dirty[w_hit_idx] <= 1'b1;
            end
        end else if (i_cmd.evict_commit) begin
            r_slot_valid[r_victim] <= 1'b1;
            r_slot_dirty[r_victim] <= 1'b0;
            r_slot_age[r_victim]   <= bbt_pkg::AGE_NEW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_commit && !w_oob && w_alloc) begin
            r_slot_tag[w_free_idx] <= w_tag;
        end else if (i_cmd.evict_commit) begin
            r_slot_tag[r_victim] <= w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best   <= bbt_pkg::AGE_RESET;
            r_victim <= '0;
            r_grp    <= '0;
        end else if (i_cmd.scan_step) begin
            r_best   <= n_best;
            r_victim <= n_victim;
            r_grp    <= r_grp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_commit) begin
            r_res_wb    <= 1'b0;
            r_res_wbblk <= '0;
            if (w_oob) begin
                r_res_status <= bbt_pkg::ST_OOB;
                r_res_slot   <= '0;
            end else if (w_alloc) begin
                r_res_status <= bbt_pkg::ST_OK;
                r_res_slot   <= w_free_idx;
            end else if (w_hit) begin
                r_res_status <= bbt_pkg::ST_OK;
                r_res_slot   <= w_hit_idx;
            end else begin
                r_res_status <= bbt_pkg::ST_MISS;
                r_res_slot   <= '0;
            end
        end else if (i_cmd.evict_commit) begin
            r_res_status <= bbt_pkg::ST_OK;
            r_res_slot   <= r_victim;
            r_res_wb     <= r_slot_dirty[r_victim];
            r_res_wbblk  <= r_slot_dirty[r_victim] ? r_slot_tag[r_victim] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_slot   <= SLOT_OUT_W'(r_res_slot);
            r_o_wb     <= r_res_wb;
            r_o_wbblk  <= WB_BLK_W'(r_res_wbblk);
        end
    end

    assign o_status          = r_o_status;
    assign o_slot            = r_o_slot;
    assign o_writeback       = r_o_wb;
    assign o_writeback_block = r_o_wbblk;

    // An allocation committed directly must have found a free slot.
    a_alloc_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval_commit && w_alloc && !w_oob) |-> w_free)
        else $error("allocation committed without a free slot");

    // Eviction only happens when every slot is in use.
    a_evict_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict_commit |-> (&r_slot_valid))
        else $error("eviction while a slot was still free");

    // The freshly allocated slot is valid afterwards.
    a_alloc_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval_commit && w_alloc && !w_oob) |=> r_slot_valid[$past(w_free_idx)])
        else $error("allocated slot not marked valid");

endmodule

// ===== design/bbt_ctrl.sv =====
// Controller of the block buffer tag table: request sequencing state machine
// and output valid flag. Uses bbt_pkg for the datapath command and status types.

module bbt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output bbt_pkg::t_dp_cmd  o_cmd,
    input  bbt_pkg::t_dp_sts  i_sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_EVICT = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.oob && i_sts.is_alloc && !i_sts.free_found) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.eval_commit = 1'b1;
                    n_state           = S_RESP;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                o_cmd.evict_commit = 1'b1;
                n_state            = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // An accepted request is evaluated in the following cycle.
    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_EVAL))
        else $error("accepted request not evaluated next");

    // The last group of the victim search leads straight to the eviction.
    a_scan_to_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_last) |=> (r_state == S_EVICT))
        else $error("victim search did not end in eviction");

    // Loading a result presents it and frees the input side.
    a_load_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not present the result");

endmodule

// ===== design/block_buffer_tag_table_core.sv =====
// Top level of the block buffer tag table: joins the controller and the
// datapath. Depends on bbt_pkg, bbt_ctrl and bbt_dp.
//
// Usage. Each request carries an operation (allocate, lookup, mark dirty)
// and a disk block number on i_func and i_block_num, qualified by i_valid;
// the block takes a request at a rising edge where i_valid is high and
// o_stall is low. Each request yields exactly one result on o_status,
// o_slot, o_writeback and o_writeback_block, qualified by o_valid and taken
// at an edge where i_stall is low.
// Processing. Out-of-bound requests, lookups, mark-dirty requests and
// allocations that find a free slot pass from acceptance through the
// evaluate and respond states into the output register, and the next
// request is taken only once the result has left the respond state.
// An allocation into a full table also searches the slot ages eight per
// cycle, in the scan state, before it evicts the chosen victim in the
// evict state; that age search makes it the slowest kind of request.
// Stalling. o_stall is high from acceptance until the result moves into
// the output register, so the next request is accepted and processed while
// the previous result is still stalled; a finished result then waits, with
// the input held off, until the receiver takes the one in front of it.
// Reset. A synchronous, active-low reset frees every slot, clears the dirty
// flags, sets all ages to minus one and empties the output register. Tags
// need no reset as they are only read for valid slots.

module block_buffer_tag_table_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bbt_pkg::FUNC_W-1:0]        i_func,
    input  logic [bbt_pkg::BLK_W-1:0]         i_block_num,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bbt_pkg::STATUS_W-1:0]      o_status,
    output logic [bbt_pkg::SLOT_OUT_W-1:0]    o_slot,
    output logic                              o_writeback,
    output logic [bbt_pkg::WB_BLK_W-1:0]      o_writeback_block
);

    // Commands from the controller and status back from the datapath.
    bbt_pkg::t_dp_cmd w_cmd;
    bbt_pkg::t_dp_sts w_sts;

    bbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // The datapath holds the slot table and every payload register.
    bbt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_func            (i_func),
        .i_block_num       (i_block_num),
        .o_status          (o_status),
        .o_slot            (o_slot),
        .o_writeback       (o_writeback),
        .o_writeback_block (o_writeback_block)
    );

endmodule
